// ===== design/rme_pkg.sv =====
// Shared types and codes for the modular exponentiation block.
// No dependencies; imported by the interface users, the top level and the checker.
package rme_pkg;

  localparam int VALUE_W    = 64;
  localparam int POWER_W    = 32;
  localparam int CFG_DATA_W = 64;

  localparam logic [1:0] CMD_ENCRYPT = 2'd0;
  localparam logic [1:0] CMD_DECRYPT = 2'd1;
  localparam logic [1:0] CMD_VERIFY  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MOD_SMALL = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;

  typedef enum logic [0:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [VALUE_W-1:0] value;
    logic [7:0]         expected_byte;
  } in_item_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [1:0]         status;
    logic               match;
  } out_item_t;

endpackage

// ===== design/rme_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type comes in as a parameter; used with rme_pkg item types.
interface rme_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rsa_modexp_cipher_top.sv =====
// Modular exponentiation engine: value ^ key_exponent mod modulus, binary square-and-multiply.
// Depends on rme_pkg and rme_stream_if.
//
// One transaction at a time. An accepted item first has its 64-bit value reduced by the
// modulus, one bit per cycle. Then for every exponent bit, LSB first, there is a setup step,
// a multiply of the accumulator by the base when the bit is set, and a squaring of the base;
// each modular product runs through one shared shift-add-reduce unit. A modulus of 255 or
// less goes straight to the finish state and returns the error status. in_chan.ready is
// high only while the engine is idle. The result sits in an output register, so the engine
// goes idle as soon as that register is free.
// Write cfg_* only while idle.
module rsa_modexp_cipher_top #(
  parameter int MODULUS_BITS  = 32,
  parameter int EXPONENT_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rme_stream_if.sink                       in_chan,
  rme_stream_if.source                     out_chan,
  input  logic                             cfg_we,
  input  rme_pkg::reg_index_t              cfg_index,
  input  logic [rme_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rme_pkg::*;

  localparam int MB     = MODULUS_BITS;
  localparam int W2     = MB + 2;
  localparam int CNT_W  = ($clog2(VALUE_W) > $clog2(MB)) ? $clog2(VALUE_W) : $clog2(MB);
  localparam int ECNT_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  state_t                   state_r;
  logic [MB-1:0]            modulus_r;
  logic [EXPONENT_BITS-1:0] key_exp_r;

  logic [1:0]               cmd_r;
  logic [7:0]               expect_r;
  logic                     small_r;
  logic [VALUE_W-1:0]       val_sh_r;
  logic [EXPONENT_BITS-1:0] exp_sh_r;
  logic [ECNT_W-1:0]        ecnt_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [MB-1:0]            r_r;
  logic [MB-1:0]            op_x_r;
  logic [MB-1:0]            op_y_r;
  logic [MB-1:0]            acc_r;
  logic [MB-1:0]            base_r;

  logic                     out_valid_r;
  out_item_t                out_data_r;

  // Shared unit: r <- (2r + addend) mod n, with r, addend < n so the sum stays below 3n
  logic [MB-1:0] unit_add;
  logic [W2-1:0] unit_sum;
  logic [W2-1:0] unit_n;
  logic [W2-1:0] unit_2n;
  logic [MB-1:0] unit_res;

  always_comb begin
    if (state_r == ST_REDUCE) begin
      unit_add = MB'(val_sh_r[VALUE_W-1]);
    end else begin
      unit_add = op_x_r[MB-1] ? op_y_r : '0;
    end
    unit_sum = {1'b0, r_r, 1'b0} + {2'b00, unit_add};
    unit_n   = {2'b00, modulus_r};
    unit_2n  = {1'b0, modulus_r, 1'b0};
    priority if (unit_sum >= unit_2n) begin
      unit_res = MB'(unit_sum - unit_2n);
    end else if (unit_sum >= unit_n) begin
      unit_res = MB'(unit_sum - unit_n);
    end else begin
      unit_res = MB'(unit_sum);
    end
  end

  logic      mod_small;
  out_item_t fin_item;

  assign mod_small = (modulus_r[MB-1:8] == '0);

  always_comb begin
    fin_item = '0;
    if (small_r) begin
      fin_item.status = STATUS_MOD_SMALL;
    end else begin
      fin_item.power = POWER_W'(acc_r);
      if (cmd_r == CMD_DECRYPT || cmd_r == CMD_VERIFY) begin
        if (acc_r[MB-1:8] != '0) begin
          fin_item.status = STATUS_RANGE;
        end else if (cmd_r == CMD_VERIFY) begin
          fin_item.match = (acc_r[7:0] == expect_r);
        end
      end
    end
  end

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= '0;
      key_exp_r   <= EXPONENT_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODULUS:  modulus_r <= cfg_wdata[MB-1:0];
          REG_EXPONENT: key_exp_r <= cfg_wdata[EXPONENT_BITS-1:0];
          default:      ;
        endcase
      end

      // the finish state reloads the output register itself
      if (out_valid_r && out_chan.ready && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            cmd_r    <= in_chan.data.command;
            expect_r <= in_chan.data.expected_byte;
            val_sh_r <= in_chan.data.value;
            small_r  <= mod_small;
            r_r      <= '0;
            cnt_r    <= CNT_W'(VALUE_W - 1);
            state_r  <= mod_small ? ST_FINISH : ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          r_r      <= unit_res;
          val_sh_r <= {val_sh_r[VALUE_W-2:0], 1'b0};
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            base_r   <= unit_res;
            acc_r    <= MB'(1);
            exp_sh_r <= key_exp_r;
            ecnt_r   <= ECNT_W'(EXPONENT_BITS - 1);
            state_r  <= ST_STEP;
          end
        end
        ST_STEP: begin
          r_r    <= '0;
          cnt_r  <= CNT_W'(MB - 1);
          op_y_r <= base_r;
          if (exp_sh_r[0]) begin
            op_x_r  <= acc_r;
            state_r <= ST_MUL;
          end else begin
            op_x_r  <= base_r;
            state_r <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (cnt_r == '0) begin
            // accumulator done; square the base next
            acc_r   <= unit_res;
            r_r     <= '0;
            cnt_r   <= CNT_W'(MB - 1);
            op_x_r  <= base_r;
            op_y_r  <= base_r;
            state_r <= ST_SQR;
          end else begin
            r_r    <= unit_res;
            op_x_r <= {op_x_r[MB-2:0], 1'b0};
            cnt_r  <= cnt_r - 1'b1;
          end
        end
        ST_SQR: begin
          r_r    <= unit_res;
          op_x_r <= {op_x_r[MB-2:0], 1'b0};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            base_r   <= unit_res;
            exp_sh_r <= exp_sh_r >> 1;
            ecnt_r   <= ecnt_r - 1'b1;
            state_r  <= (ecnt_r == '0) ? ST_FINISH : ST_STEP;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid_r || out_chan.ready) begin
            out_data_r  <= fin_item;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/rme_checker.sv =====
// Port-level checks for rsa_modexp_cipher_top, attached by the bind at the end.
// Depends on rme_pkg for item types and status codes.
module rme_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rme_pkg::out_item_t out_data
);
  import rme_pkg::*;

  // engine takes one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while engine busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_small_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_MOD_SMALL |-> out_data.power == '0 && !out_data.match)
    else $error("modulus error carries nonzero payload");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match |-> out_data.status == STATUS_OK && out_data.power[31:8] == '0)
    else $error("match set with bad status or wide power");

  a_range_wide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_RANGE |-> out_data.power[31:8] != '0)
    else $error("range status on a power below 256");

endmodule

bind rsa_modexp_cipher_top rme_checker u_rme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rsa_modexp_cipher_top: directed rows, then randomized key phases.
// Depends on rme_pkg, rme_stream_if and the top level; holds its own modexp predictor.
module testbench;
  import rme_pkg::*;

  // The package names three commands; the fourth code behaves as encrypt.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 17;
  localparam int DRAIN_CYCLES = 4300;

  typedef struct {
    bit          is_write;
    reg_index_t  idx;
    logic [63:0] wdata;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  reg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rme_stream_if #(.payload_t(in_item_t)) in_ch ();
  rme_stream_if #(.payload_t(out_item_t)) res_ch ();

  rsa_modexp_cipher_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_ch),
    .out_chan(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Key registers as the block should hold them.
  logic [31:0] modulus_q;
  logic [63:0] exponent_q;

  out_item_t pending_results[$];
  plan_row_t plan[$];
  out_item_t seen_res;
  out_item_t due_res;
  bit steady;
  int fault_count;
  int items_sent;
  int directed_items;
  int results_seen;
  int reg_writes;
  int verify_hits;
  int range_flags;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic out_item_t mk_result(logic [31:0] p, logic [1:0] s, logic m);
    out_item_t r;
    r.power = p;
    r.status = s;
    r.match = m;
    return r;
  endfunction

  // Square-and-multiply over all exponent bits, LSB first.
  function automatic out_item_t modexp_predict(in_item_t it);
    bit [63:0] n;
    bit [63:0] acc;
    bit [63:0] base;
    out_item_t r;
    n = {32'd0, modulus_q};
    r = '0;
    if (n <= 64'd255) begin
      r.status = STATUS_MOD_SMALL;
      return r;
    end
    acc = 64'd1 % n;
    base = it.value % n;
    for (int i = 0; i < 64; i++) begin
      if (exponent_q[i]) acc = (acc * base) % n;
      base = (base * base) % n;
    end
    r.power = acc[31:0];
    if (it.command == CMD_DECRYPT || it.command == CMD_VERIFY) begin
      if (acc > 64'd255) r.status = STATUS_RANGE;
      else if (it.command == CMD_VERIFY) r.match = (acc[7:0] == it.expected_byte);
    end
    return r;
  endfunction

  function automatic void add_write(reg_index_t idx, logic [63:0] data);
    plan_row_t row;
    row = '{is_write: 1'b0, idx: REG_MODULUS, wdata: '0, item: '0, typed: 1'b0, want: '0};
    row.is_write = 1'b1;
    row.idx = idx;
    row.wdata = data;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_item(logic [1:0] cmd, logic [63:0] value, logic [7:0] byte_in,
                                   bit typed, out_item_t want);
    plan_row_t row;
    row = '{is_write: 1'b0, idx: REG_MODULUS, wdata: '0, item: '0, typed: 1'b0, want: '0};
    row.item.command = cmd;
    row.item.value = value;
    row.item.expected_byte = byte_in;
    row.typed = typed;
    row.want = want;
    plan.insert(plan.size(), row);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), typed ? want : modexp_predict(it));
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) modulus_q = data[31:0];
    else exponent_q = data;
    reg_writes++;
  endtask

  function automatic logic [63:0] pick_value(logic [31:0] n);
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'($urandom_range(0, 300));
      3: return {32'd0, n - 32'd1};
      4: return {32'd0, n} + 64'($urandom_range(0, 255));
      5: return '1;
      6: return {$urandom, $urandom};
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_exponent();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'd2;
      3: return 64'd65537;
      4: return '1;
      7: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus(int phase);
    if (phase == 0) return 32'hFFFF_FFFF;
    if (phase == 5) return 32'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 32'd256 + 32'($urandom_range(0, 255));
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000 | $urandom;
      default: return $urandom | 32'h0000_0100;
    endcase
  endfunction

  // Directed rows: error paths first, then boundary keys, then a textbook key pair.
  function automatic void build_plan();
    add_item(CMD_ENCRYPT, 64'd5, 8'd0, 1, mk_result(0, STATUS_MOD_SMALL, 0));
    add_item(CMD_VERIFY, '1, 8'hFF, 1, mk_result(0, STATUS_MOD_SMALL, 0));
    add_write(REG_MODULUS, 64'd1);
    add_item(CMD_DECRYPT, 64'd0, 8'd0, 1, mk_result(0, STATUS_MOD_SMALL, 0));
    add_write(REG_MODULUS, {32'hFFFF_FFFF, 32'd255});
    add_item(CMD_SPARE, 64'd1000, 8'd0, 1, mk_result(0, STATUS_MOD_SMALL, 0));
    add_write(REG_MODULUS, 64'd256);
    add_item(CMD_ENCRYPT, 64'd300, 8'd0, 0, '0);
    add_write(REG_EXPONENT, 64'd0);
    add_item(CMD_ENCRYPT, 64'h1234, 8'd0, 1, mk_result(1, STATUS_OK, 0));
    add_item(CMD_VERIFY, 64'd0, 8'd1, 1, mk_result(1, STATUS_OK, 1));
    add_item(CMD_DECRYPT, '1, 8'd0, 1, mk_result(1, STATUS_OK, 0));
    add_write(REG_MODULUS, 64'hFFFF_FFFF);
    add_write(REG_EXPONENT, '1);
    add_item(CMD_ENCRYPT, 64'd0, 8'd0, 1, mk_result(0, STATUS_OK, 0));
    add_item(CMD_ENCRYPT, '1, 8'hA5, 0, '0);
    add_item(CMD_VERIFY, 64'd1, 8'd1, 1, mk_result(1, STATUS_OK, 1));
    add_item(CMD_VERIFY, 64'd1, 8'd0, 1, mk_result(1, STATUS_OK, 0));
    add_item(CMD_DECRYPT, 64'h0000_0001_0000_0000, 8'd0, 0, '0);
    add_item(CMD_SPARE, 64'hFFFF_FFFE, 8'd0, 0, '0);
    add_write(REG_EXPONENT, 64'd1);
    add_item(CMD_DECRYPT, 64'd255, 8'd0, 1, mk_result(255, STATUS_OK, 0));
    add_item(CMD_DECRYPT, 64'd256, 8'd0, 1, mk_result(256, STATUS_RANGE, 0));
    add_item(CMD_VERIFY, 64'd200, 8'd200, 1, mk_result(200, STATUS_OK, 1));
    add_item(CMD_VERIFY, 64'd200, 8'd201, 1, mk_result(200, STATUS_OK, 0));
    add_item(CMD_VERIFY, 64'd256, 8'd0, 1, mk_result(256, STATUS_RANGE, 0));
    add_item(CMD_SPARE, 64'd256, 8'd0, 1, mk_result(256, STATUS_OK, 0));
    add_item(CMD_ENCRYPT, 64'hFFFF_FFFF, 8'd0, 1, mk_result(0, STATUS_OK, 0));
    add_write(REG_MODULUS, 64'd3233);
    add_write(REG_EXPONENT, 64'd17);
    add_item(CMD_ENCRYPT, 64'd65, 8'd0, 0, '0);
    add_write(REG_EXPONENT, 64'd2753);
    add_item(CMD_DECRYPT, 64'd2790, 8'd0, 0, '0);
    add_item(CMD_VERIFY, 64'd2790, 8'd65, 0, '0);
  endfunction

  // Sink side: hold off now and then, except during the steady stretch.
  always @(negedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen_res = res_ch.data;
      results_seen++;
      if (seen_res.match) verify_hits++;
      if (seen_res.status == STATUS_RANGE) range_flags++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: power %h status %0d match %0d",
               seen_res.power, seen_res.status, seen_res.match);
        fault_count++;
      end else begin
        due_res = pending_results.pop_front();
        if (seen_res.power !== due_res.power) begin
          $error("power: expected %h, got %h", due_res.power, seen_res.power);
          fault_count++;
        end
        if (seen_res.status !== due_res.status) begin
          $error("status: expected %0d, got %0d", due_res.status, seen_res.status);
          fault_count++;
        end
        if (seen_res.match !== due_res.match) begin
          $error("match: expected %0d, got %0d", due_res.match, seen_res.match);
          fault_count++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t guess;
    logic [63:0] mod_word;
    logic [63:0] exp_word;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    res_ch.ready = 1'b0;
    steady = 1'b0;
    modulus_q = '0;
    exponent_q = 64'd1;
    build_plan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end
    directed_items = items_sent;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      steady = (ph == 3);
      mod_word = {$urandom, pick_modulus(ph)};
      exp_word = (ph == 0) ? '1 : pick_exponent();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_MODULUS, mod_word);
        write_reg(REG_EXPONENT, exp_word);
      end else begin
        write_reg(REG_EXPONENT, exp_word);
        write_reg(REG_MODULUS, mod_word);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it.command = 2'($urandom_range(0, 3));
        it.value = pick_value(modulus_q);
        it.expected_byte = 8'($urandom_range(0, 255));
        // Aim verify at the decoded byte half the time so matches actually occur.
        guess = modexp_predict(it);
        if (it.command == CMD_VERIFY && guess.power <= 32'd255 && $urandom_range(0, 1))
          it.expected_byte = guess.power[7:0];
        send_item(it, 1'b0, '0);
      end
    end

    steady = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transactions (%0d directed) across %0d key register writes.",
             items_sent, directed_items, reg_writes);
    $display("Checked %0d results: %0d verify matches, %0d out-of-range decodes, %0d faults.",
             results_seen, verify_hits, range_flags, fault_count);
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Timeout guard in case the run hangs; it reports NOT OK.
  initial begin
    #60000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
